>>> hw/rtl/epm_pkg.sv
// Shared constants and the twist table for the entropy pool mixer.
// No dependencies; used by the pool memory and the top level.
`timescale 1ns / 1ps
`default_nettype none

package epm_pkg;

    localparam int POOL_WORDS_DEF = 32;
    localparam int WORD_W         = 32;
    localparam int SLOT_OUT_W     = 5;
    localparam int ROT_W          = 5;

    localparam int SLOT_STEP = 67;
    localparam int TAP_OFF_0 = 127;
    localparam int TAP_OFF_1 = 28;
    localparam int TAP_OFF_2 = 26;
    localparam int TAP_OFF_3 = 1;

    localparam logic [ROT_W-1:0] ROT_STEP      = 5'd7;
    localparam logic [ROT_W-1:0] ROT_STEP_WRAP = 5'd14;

    localparam int               NUM_READS = 5;
    localparam logic [2:0]       LAST_READ = 3'(NUM_READS - 1);

    function automatic logic [WORD_W-1:0] twist(input logic [2:0] sel);
        logic [WORD_W-1:0] val;
        case (sel)
            3'd0:    val = 32'h0000_0000;
            3'd1:    val = 32'h3b6e_20c8;
            3'd2:    val = 32'h76dc_4190;
            3'd3:    val = 32'h4db2_6158;
            3'd4:    val = 32'hedb8_8320;
            3'd5:    val = 32'hd6d6_a3e8;
            3'd6:    val = 32'h9b64_c2b0;
            3'd7:    val = 32'ha00a_e278;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/epm_pool_mem.sv
// Pool storage: one synchronous read port, one write port, per-entry valid bits.
// Depends on epm_pkg; unwritten entries read as zero after reset.
`timescale 1ns / 1ps
`default_nettype none

module epm_pool_mem #(
    parameter int POOL_WORDS = epm_pkg::POOL_WORDS_DEF,
    parameter int IDX_W      = $clog2(POOL_WORDS)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [IDX_W-1:0]           rd_addr,
    output logic [epm_pkg::WORD_W-1:0]      rd_data,
    input  wire logic                       wr_en,
    input  wire logic [IDX_W-1:0]           wr_addr,
    input  wire logic [epm_pkg::WORD_W-1:0] wr_data
);

    logic [epm_pkg::WORD_W-1:0] pool_mem [POOL_WORDS];
    logic [epm_pkg::WORD_W-1:0] data_reg;
    logic                       hit_reg;
    logic [POOL_WORDS-1:0]      valid_reg;
    logic [POOL_WORDS-1:0]      valid_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pool_mem[wr_addr] <= wr_data;
        end
        data_reg <= pool_mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= valid_reg[rd_addr];
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

>>> hw/rtl/entropy_pool_lfsr_mixer.sv
// Top level of the entropy pool mixer: sequencer, address and mixing datapath.
// Depends on epm_pkg and epm_pool_mem.
`timescale 1ns / 1ps
`default_nettype none

// Folds one 32-bit event word per command into a pool of POOL_WORDS words.
// A word is taken when start is high while busy is low; busy then stays high
// while the slot and its four taps are read in turn through the single read
// port of the pool memory, then while the word is mixed and written back.
// The result (mixed_word, slot_index) is shown with done high for one cycle
// right after, and a new word may be started in that same cycle; start is
// ignored while busy. The pool reads as all zero after reset with no
// clearing pass. The receiver cannot stall; results must be captured when
// done is high.
module entropy_pool_lfsr_mixer #(
    parameter int POOL_WORDS = epm_pkg::POOL_WORDS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [epm_pkg::WORD_W-1:0]        event_word,
    output logic                                   done,
    output logic [epm_pkg::WORD_W-1:0]             mixed_word,
    output logic [epm_pkg::SLOT_OUT_W-1:0]         slot_index
);

    localparam int IDX_W = $clog2(POOL_WORDS);
    localparam int SUM_W = IDX_W + 1;

    localparam logic [SUM_W-1:0] POOL_SIZE = SUM_W'(POOL_WORDS);
    localparam logic [SUM_W-1:0] STEP_MOD  = SUM_W'(epm_pkg::SLOT_STEP % POOL_WORDS);
    localparam logic [SUM_W-1:0] TAP0_MOD  = SUM_W'(epm_pkg::TAP_OFF_0 % POOL_WORDS);
    localparam logic [SUM_W-1:0] TAP1_MOD  = SUM_W'(epm_pkg::TAP_OFF_1 % POOL_WORDS);
    localparam logic [SUM_W-1:0] TAP2_MOD  = SUM_W'(epm_pkg::TAP_OFF_2 % POOL_WORDS);
    localparam logic [SUM_W-1:0] TAP3_MOD  = SUM_W'(epm_pkg::TAP_OFF_3 % POOL_WORDS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RD   = 3'b010,
        ST_WR   = 3'b100
    } epm_state_t;

    epm_state_t                      state_reg, state_next;
    logic [2:0]                      step_reg, step_next;
    logic [IDX_W-1:0]                slot_reg, slot_next;
    logic [epm_pkg::ROT_W-1:0]       rot_reg, rot_next;
    logic [epm_pkg::WORD_W-1:0]      word_reg, word_next;
    logic [epm_pkg::WORD_W-1:0]      acc_reg, acc_next;
    logic                            done_reg, done_next;
    logic [epm_pkg::WORD_W-1:0]      mixed_reg, mixed_next;

    logic                            accept;
    logic [SUM_W-1:0]                slot_sum;
    logic [SUM_W-1:0]                tap_off;
    logic [SUM_W-1:0]                tap_sum;
    logic [IDX_W-1:0]                rd_addr;
    logic [epm_pkg::WORD_W-1:0]      rd_data;
    logic                            wr_en;
    logic [epm_pkg::WORD_W-1:0]      fold;
    logic [2*epm_pkg::WORD_W-1:0]    rot_wide;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // advance the pointer
    assign slot_sum = {1'b0, slot_reg} + STEP_MOD;

    always_comb
    begin
        case (step_reg)
            3'd0:    tap_off = '0;
            3'd1:    tap_off = TAP0_MOD;
            3'd2:    tap_off = TAP1_MOD;
            3'd3:    tap_off = TAP2_MOD;
            3'd4:    tap_off = TAP3_MOD;
            default: tap_off = '0;
        endcase
    end

    assign tap_sum = {1'b0, slot_reg} + tap_off;
    assign rd_addr = (tap_sum >= POOL_SIZE) ? IDX_W'(tap_sum - POOL_SIZE)
                                            : IDX_W'(tap_sum);

    assign rot_wide = {word_reg, word_reg} << rot_reg;
    assign fold     = acc_reg ^ rd_data;
    assign wr_en    = (state_reg == ST_WR);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        rot_next   = rot_reg;
        word_next  = word_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        mixed_next = mixed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    slot_next  = (slot_sum >= POOL_SIZE) ? IDX_W'(slot_sum - POOL_SIZE)
                                                         : IDX_W'(slot_sum);
                    rot_next   = rot_reg + ((slot_next == '0) ? epm_pkg::ROT_STEP_WRAP
                                                              : epm_pkg::ROT_STEP);
                    word_next  = event_word;
                    step_next  = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                if (step_reg == '0)
                begin
                    acc_next = rot_wide[2*epm_pkg::WORD_W-1:epm_pkg::WORD_W];
                end
                else
                begin
                    acc_next = fold;
                end
                if (step_reg == epm_pkg::LAST_READ)
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_WR:
            begin
                mixed_next = (fold >> 3) ^ epm_pkg::twist(fold[2:0]);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            slot_reg  <= '0;
            rot_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            slot_reg  <= slot_next;
            rot_reg   <= rot_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        acc_reg   <= acc_next;
        mixed_reg <= mixed_next;
    end

    epm_pool_mem #(
        .POOL_WORDS (POOL_WORDS),
        .IDX_W      (IDX_W)
    ) u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (mixed_next)
    );

    assign done       = done_reg;
    assign mixed_word = mixed_reg;
    assign slot_index = slot_reg[epm_pkg::SLOT_OUT_W-1:0];

`ifndef NO_ASSERTIONS
    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_WR))
        else $error("done without a preceding write-back");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_RD) && (step_reg == '0))
        else $error("accepted word did not start the read sequence");

    a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> $past(state_reg == ST_RD)
                                 && $past(step_reg == epm_pkg::LAST_READ))
        else $error("write-back before all pool reads issued");

    a_slot_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !$past(accept)) |-> $stable(slot_reg) && $stable(rot_reg))
        else $error("slot or rotation changed mid-word");
`endif

endmodule

`default_nettype wire
